>>> src/rfwp_pkg.sv
`default_nettype none
package rfwp_pkg;

  localparam logic [31:0] END_MARK      = 32'hFAFA_FAFA;
  localparam logic [23:0] HDR_RAW       = 24'h41_4443;
  localparam logic [23:0] HDR_ZSP       = 24'h41_505A;
  localparam logic [15:0] SIZE_TAG      = 16'hAABB;
  localparam logic [7:0]  MAX_SEG_RESET = 8'd16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_RAW  = 2'd1,
    MODE_ZSP  = 2'd2
  } mode_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data_word;
    logic [7:0]  segment;
    logic [7:0]  chip_number;
    logic [7:0]  board_out;
    mode_t       mode;
    logic        no_markers;
    logic        board_bad;
    logic        segment_overflow;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

>>> src/rfwp_parse.sv
`default_nettype none
module rfwp_parse
  import rfwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [31:0] word,
  input  wire logic [7:0]  board_number,
  input  wire logic        end_of_frame,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output push_t            push
);

  logic [31:0] held_word_r, held_word_nxt;
  logic        held_valid_r, held_valid_nxt;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  chip_r, chip_nxt;
  logic        halted_r, halted_nxt;
  logic        ovf_r, ovf_nxt;
  logic        frame_started_r;
  logic [7:0]  max_seg_r;

  logic        hv_e;
  mode_t       mode_e;
  logic [7:0]  count_e;
  logic        halted_e;
  logic [23:0] tag;
  logic        is_pay;
  logic        emit_a;
  logic        emit_b;
  logic        emit_held;
  result_t     held_res;
  result_t     stat_res;

  always_comb begin
    hv_e     = frame_started_r & held_valid_r;
    mode_e   = frame_started_r ? mode_r : MODE_NONE;
    count_e  = frame_started_r ? count_r : 8'd0;
    halted_e = frame_started_r & halted_r;
    tag      = word[31:8];

    held_word_nxt  = held_word_r;
    held_valid_nxt = hv_e;
    mode_nxt       = mode_e;
    count_nxt      = count_e;
    chip_nxt       = frame_started_r ? chip_r : 8'd0;
    halted_nxt     = halted_e;
    ovf_nxt        = frame_started_r & ovf_r;
    is_pay         = 1'b0;

    if (!halted_e) begin
      if (word == END_MARK) begin
        halted_nxt     = 1'b1;
        held_valid_nxt = 1'b0;
        chip_nxt       = 8'd0;
        count_nxt      = 8'd0;
      end else if (word[31:16] == SIZE_TAG) begin
        held_valid_nxt = hv_e;
      end else if (tag == HDR_RAW || tag == HDR_ZSP) begin
        mode_nxt       = (tag == HDR_RAW) ? MODE_RAW : MODE_ZSP;
        chip_nxt       = word[7:0];
        held_valid_nxt = 1'b0;
        if (count_e >= max_seg_r) begin
          ovf_nxt    = 1'b1;
          halted_nxt = 1'b1;
        end else begin
          count_nxt = count_e + 8'd1;
        end
      end else if (mode_e != MODE_NONE) begin
        is_pay = 1'b1;
        if (end_of_frame) begin
          held_valid_nxt = 1'b0;
        end else begin
          held_word_nxt  = (mode_e == MODE_RAW) ? swap_bytes(word) : word;
          held_valid_nxt = 1'b1;
        end
      end
    end

    emit_a = is_pay & hv_e;
    emit_b = end_of_frame & held_valid_nxt;
    if (emit_b) begin
      held_valid_nxt = 1'b0;
    end
    emit_held = emit_a | emit_b;

    held_res                  = '0;
    held_res.kind             = KIND_PAYLOAD;
    held_res.data_word        = held_word_r;
    held_res.segment          = count_nxt;
    held_res.board_out        = board_number;
    held_res.mode             = MODE_NONE;
    held_res.last             = ~end_of_frame;

    stat_res                  = '0;
    stat_res.kind             = KIND_STATUS;
    stat_res.segment          = count_nxt;
    stat_res.chip_number      = chip_nxt;
    stat_res.board_out        = board_number;
    stat_res.mode             = mode_nxt;
    stat_res.no_markers       = (mode_nxt == MODE_NONE);
    stat_res.board_bad        = (board_number == 8'd0);
    stat_res.segment_overflow = ovf_nxt;
    stat_res.last             = 1'b1;

    push.first  = emit_held ? held_res : stat_res;
    push.second = stat_res;
    if (!accept) begin
      push.n = 2'd0;
    end else begin
      push.n = {1'b0, emit_held} + {1'b0, end_of_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_word_r     <= '0;
      held_valid_r    <= 1'b0;
      mode_r          <= MODE_NONE;
      count_r         <= 8'd0;
      chip_r          <= 8'd0;
      halted_r        <= 1'b0;
      ovf_r           <= 1'b0;
      frame_started_r <= 1'b0;
    end else if (accept) begin
      held_word_r     <= held_word_nxt;
      held_valid_r    <= held_valid_nxt;
      mode_r          <= mode_nxt;
      count_r         <= count_nxt;
      chip_r          <= chip_nxt;
      halted_r        <= halted_nxt;
      ovf_r           <= ovf_nxt;
      frame_started_r <= ~end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_seg_r <= MAX_SEG_RESET;
    end else if (cfg_we) begin
      max_seg_r <= cfg_wdata;
    end
  end

`ifndef SYNTHESIS
  a_two_only_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> end_of_frame && push.second.kind == KIND_STATUS)
    else $error("two results pushed without end of frame");
  a_halt_keeps_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_started_r && halted_r |-> !held_valid_r)
    else $error("held word valid while frame is halted");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 && push.first.kind == KIND_STATUS |-> push.n == 2'd1)
    else $error("status pushed before a payload word");
`endif

endmodule
`default_nettype wire

>>> src/rfwp_outq.sv
`default_nettype none
module rfwp_outq
  import rfwp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   head
);

  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign head      = q_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("push into queue without room");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.n == 2'd0 |=> cnt_r == $past(cnt_r) - QCNT_W'(1))
    else $error("queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

>>> src/readout_frame_word_parser.sv
`default_nettype none
// Frame word parser for a readout link.
// The input channel (in_valid/in_ready) takes one frame word per request,
// tagged with the board number and an end-of-frame flag. The result
// channel (out_valid/out_ready) returns payload words, delayed by one word
// and tagged with their segment, and one status request at the end of
// each frame. The configuration port (cfg_we/cfg_wdata) sets the maximum
// segment count; the user must write it only while the block is idle, as
// the block itself does not enforce this. A word is parsed in the cycle
// it is accepted and its results are registered in the queue; the block
// accepts one word per cycle while in_ready is high. A word yields zero,
// one or two results; results go into a four-entry queue that drains one
// per cycle while out_ready is high, and in_ready drops while fewer than
// two entries are free, so a stalled receiver stops the input once three or
// four requests are pending. Reset empties the queue, clears all frame
// state and sets the maximum segment count to 16.
module readout_frame_word_parser
  import rfwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_word,
  input  wire logic [7:0]  in_board_number,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_data_word,
  output logic [7:0]       out_segment,
  output logic [7:0]       out_chip_number,
  output logic [7:0]       out_board_out,
  output logic [1:0]       out_mode,
  output logic             out_no_markers,
  output logic             out_board_bad,
  output logic             out_segment_overflow,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  assign in_ready = room;
  assign accept   = in_valid & room;

  rfwp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .word         (in_word),
    .board_number (in_board_number),
    .end_of_frame (in_end_of_frame),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push)
  );

  rfwp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind             = head.kind;
  assign out_data_word        = head.data_word;
  assign out_segment          = head.segment;
  assign out_chip_number      = head.chip_number;
  assign out_board_out        = head.board_out;
  assign out_mode             = head.mode;
  assign out_no_markers       = head.no_markers;
  assign out_board_bad        = head.board_bad;
  assign out_segment_overflow = head.segment_overflow;
  assign out_last             = head.last;

endmodule
`default_nettype wire
